>>> rtl/millisecond_one_shot_timer_unit_assert.svh
// Assertion macros shared by the timer RTL
`ifndef MILLISECOND_ONE_SHOT_TIMER_UNIT_ASSERT_SVH
`define MILLISECOND_ONE_SHOT_TIMER_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MOTS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MOTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/mots_pkg.sv
// Types, constants and microcode table of the one-shot millisecond timer
package mots_pkg;

	localparam int TPM_W      = 17;
	localparam int OFS_W      = 10;
	localparam int MS_W       = 32;
	localparam int PSC_W      = 15;
	localparam int MUL_A_W    = 32;
	localparam int MUL_B_W    = 17;
	localparam int MUL_W      = MUL_A_W + MUL_B_W;
	localparam int ACC_W      = MUL_W + 1;
	localparam int STEP_W     = 4;
	localparam int IN_DATA_W  = 32;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 40;
	localparam int ELAPSED_W  = 32;
	localparam int KPROD_W    = 64;

	localparam logic [MS_W-1:0]  RANGE_SHORT_MS = 32'd30000;
	localparam logic [MS_W-1:0]  RANGE_MID_MS   = 32'd3600000;
	localparam logic [PSC_W-1:0] PRESCALE_MID   = 15'd999;
	localparam logic [PSC_W-1:0] PRESCALE_LONG  = 15'd29999;
	localparam logic [TPM_W-1:0] MS_PER_S       = 17'd1000;
	localparam logic [TPM_W-1:0] DIV_LONG       = 17'd30000;
	localparam logic [TPM_W-1:0] TPM_RESET      = 17'd80000;

	// floor(x/d) = (x*ceil(2^k/d)) >> k for every 32-bit x with these pairs
	localparam logic [MS_W-1:0]  RECIP_MS_PER_S = 32'd274877907;
	localparam int               SHIFT_MS_PER_S = 38;
	localparam logic [MS_W-1:0]  RECIP_LONG     = 32'd2345624806;
	localparam int               SHIFT_LONG     = 46;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_START = 2'd1,
		REQ_STOP  = 2'd2
	} req_t;

	typedef enum logic {
		REG_TICKS_PER_MS = 1'b0,
		REG_CAL_OFFSET   = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		JMP_NONE      = 2'd0,
		JMP_NOT_START = 2'd1,
		JMP_SHORT     = 2'd2,
		JMP_ALWAYS    = 2'd3
	} jmp_t;

	typedef enum logic [2:0] {
		MA_NONE = 3'd0,
		MA_Q1   = 3'd1,
		MA_R1   = 3'd2,
		MA_MS   = 3'd3,
		MA_CNT  = 3'd4
	} mula_t;

	// constant divisions go through the reciprocal product, ticks_per_ms through the divider
	typedef enum logic [1:0] {
		DV_NONE    = 2'd0,
		DV_MS_K    = 2'd1,
		DV_MUL_K   = 2'd2,
		DV_MUL_TPM = 2'd3
	} divop_t;

	typedef enum logic [1:0] {
		ACC_NONE  = 2'd0,
		ACC_LOAD  = 2'd1,
		ACC_ADD_Q = 2'd2
	} accop_t;

	typedef struct packed {
		jmp_t              jmp;
		logic [STEP_W-1:0] target;
		mula_t             mul_a;
		divop_t            div_op;
		logic              wait_div;
		accop_t            acc_op;
		logic              latch_q1;
		logic              wr_reload;
		logic              emit;
	} cw_t;

	typedef struct packed {
		logic is_start;
		logic short_rng;
		logic div_busy;
		logic out_full;
	} seq_cond_t;

	localparam logic [STEP_W-1:0] ST_ENTRY    = 4'd0;
	localparam logic [STEP_W-1:0] ST_RANGE    = 4'd1;
	localparam logic [STEP_W-1:0] ST_DIV_MS   = 4'd2;
	localparam logic [STEP_W-1:0] ST_GET_Q1   = 4'd3;
	localparam logic [STEP_W-1:0] ST_MUL_Q1   = 4'd4;
	localparam logic [STEP_W-1:0] ST_MUL_R1   = 4'd5;
	localparam logic [STEP_W-1:0] ST_DIV_FRAC = 4'd6;
	localparam logic [STEP_W-1:0] ST_ADD_FRAC = 4'd7;
	localparam logic [STEP_W-1:0] ST_MUL_MS   = 4'd8;
	localparam logic [STEP_W-1:0] ST_LOAD_MS  = 4'd9;
	localparam logic [STEP_W-1:0] ST_RELOAD   = 4'd10;
	localparam logic [STEP_W-1:0] ST_MUL_CNT  = 4'd11;
	localparam logic [STEP_W-1:0] ST_DIV_EL   = 4'd12;
	localparam logic [STEP_W-1:0] ST_EMIT     = 4'd13;

	// microprogram: reload computation for start, then elapsed time for every item
	function automatic cw_t ucode_rom(input logic [STEP_W-1:0] addr);
		cw_t w;
		w = '0;
		case (addr)
			ST_ENTRY: begin
				w.jmp    = JMP_NOT_START;
				w.target = ST_MUL_CNT;
			end
			ST_RANGE: begin
				w.jmp    = JMP_SHORT;
				w.target = ST_MUL_MS;
			end
			ST_DIV_MS: w.div_op = DV_MS_K;
			ST_GET_Q1: w.latch_q1 = 1'b1;
			ST_MUL_Q1: w.mul_a = MA_Q1;
			ST_MUL_R1: begin
				w.acc_op = ACC_LOAD;
				w.mul_a  = MA_R1;
			end
			ST_DIV_FRAC: w.div_op = DV_MUL_K;
			ST_ADD_FRAC: begin
				w.acc_op   = ACC_ADD_Q;
				w.jmp      = JMP_ALWAYS;
				w.target   = ST_RELOAD;
			end
			ST_MUL_MS:  w.mul_a = MA_MS;
			ST_LOAD_MS: w.acc_op = ACC_LOAD;
			ST_RELOAD:  w.wr_reload = 1'b1;
			ST_MUL_CNT: w.mul_a = MA_CNT;
			ST_DIV_EL:  w.div_op = DV_MUL_TPM;
			ST_EMIT: begin
				w.wait_div = 1'b1;
				w.emit     = 1'b1;
			end
			default: begin
				w.jmp    = JMP_ALWAYS;
				w.target = ST_MUL_CNT;
			end
		endcase
		return w;
	endfunction

endpackage

>>> rtl/mots_div.sv
// Restoring divider, one quotient bit per cycle
module mots_div import mots_pkg::*; #(
	parameter int DW = 47
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DW-1:0]    dividend,
	input  logic [TPM_W-1:0] divisor,
	output logic             busy,
	output logic [DW-1:0]    quotient
);

	localparam int CNT_W = $clog2(DW + 1);

	logic [TPM_W-1:0] rem_q;
	logic [DW-1:0]    quo_q;
	logic [TPM_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic [TPM_W:0]   shifted;
	logic [TPM_W+1:0] diff;
	logic             take;

	assign shifted   = {rem_q, quo_q[DW-1]};
	assign diff      = {1'b0, shifted} - {2'b00, dvs_q};
	assign take      = !diff[TPM_W+1];
	assign busy      = (cnt_q != '0);
	assign quotient  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DW);
		end else if (busy) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy) begin
			// keep the trial difference when it did not borrow
			rem_q <= take ? diff[TPM_W-1:0] : shifted[TPM_W-1:0];
			quo_q <= {quo_q[DW-2:0], take};
		end
	end

endmodule

>>> rtl/mots_seq.sv
// Step counter and microcode lookup of the timer
module mots_seq import mots_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      launch,
	input  seq_cond_t cond,
	output cw_t       cw,
	output logic      active,
	output logic      go
);

	logic [STEP_W-1:0] step_q;
	logic              active_q;
	logic              taken;

	assign cw     = ucode_rom(step_q);
	assign active = active_q;
	// hold on a divider wait or on a full output register
	assign go     = active_q && !(cw.wait_div && cond.div_busy) && !(cw.emit && cond.out_full);

	always_comb begin
		case (cw.jmp)
			JMP_NONE:      taken = 1'b0;
			JMP_NOT_START: taken = !cond.is_start;
			JMP_SHORT:     taken = cond.short_rng;
			JMP_ALWAYS:    taken = 1'b1;
			default:       taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			step_q   <= ST_ENTRY;
		end else if (!active_q) begin
			if (launch) begin
				active_q <= 1'b1;
				step_q   <= ST_ENTRY;
			end
		end else if (go) begin
			if (cw.emit) begin
				active_q <= 1'b0;
			end else begin
				step_q <= taken ? cw.target : step_q + STEP_W'(1);
			end
		end
	end

endmodule

>>> rtl/millisecond_one_shot_timer_unit.sv
// Top level of the one-shot millisecond timer with range-selected prescaler.
// Tick and stop run only the elapsed-time steps; a start up to 30 s first gets its
// reload by one multiply, a longer one by reciprocal division. All wait on the serial
// division of DIV_W = max(COUNTER_WIDTH+15, 32) bits (47 by default) and on the output.
// One item at a time: s_tready returns once the result is in the output register.
// Reset: timer stopped, counters zero, reload all ones, ticks_per_ms 80000.
`include "millisecond_one_shot_timer_unit_assert.svh"
module millisecond_one_shot_timer_unit import mots_pkg::*; #(
	parameter int COUNTER_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // [31:0] duration_ms
	input  logic [IN_USER_W-1:0]  s_tuser,  // [1:0] req_type
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // [0] expired, [1] running, [33:2] elapsed_ms
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [TPM_W-1:0]      cfg_data
);

	// divider width covers both the millisecond value and counter*(prescale+1)
	localparam int DIV_W = (COUNTER_WIDTH + PSC_W > MS_W) ? COUNTER_WIDTH + PSC_W : MS_W;
	localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;

	// configuration
	logic [TPM_W-1:0]         tpm_q;
	logic [OFS_W-1:0]         ofs_q;
	// timer state
	logic                     enabled_q;
	logic [PSC_W-1:0]         psc_val_q;
	logic [PSC_W-1:0]         psc_cnt_q;
	logic [COUNTER_WIDTH-1:0] up_cnt_q;
	logic [COUNTER_WIDTH-1:0] reload_q;
	// item held for the microprogram
	logic [MS_W-1:0]          ms_q;
	logic                     start_q;
	logic                     short_q;
	logic                     long_q;
	logic                     exp_q;
	// datapath
	logic [MS_W-1:0]          q1_q;
	logic [PSC_W-1:0]         r1_q;
	logic [MUL_W-1:0]         mul_q;
	logic [ACC_W-1:0]         acc_q;
	logic [KPROD_W-1:0]       kprod_q;
	logic                     m_tvalid_q;
	logic [OUT_DATA_W-1:0]    m_tdata_q;

	logic                     accept;
	logic                     in_short;
	logic                     in_long;
	logic [PSC_W-1:0]         psc_sel;
	logic                     tick_wrap;
	logic                     tick_expire;
	cw_t                      seq_cw;
	logic                     seq_active;
	logic                     seq_go;
	seq_cond_t                seq_cond;
	logic [MUL_A_W-1:0]       mul_a_op;
	logic [MUL_B_W-1:0]       mul_b_op;
	logic [MUL_W-1:0]         mul_res;
	logic                     kdiv_start;
	logic [MS_W-1:0]          kdiv_x;
	logic [MS_W-1:0]          kdiv_m;
	logic [MS_W-1:0]          kdiv_d;
	logic [MS_W-1:0]          kquo;
	logic [MS_W-1:0]          krem;
	logic                     div_start;
	logic [DIV_W-1:0]         div_dividend;
	logic [TPM_W-1:0]         div_divisor;
	logic                     div_busy;
	logic [DIV_W-1:0]         div_quo;
	logic [ACC_W-1:0]         rel_sum;
	logic                     rel_sat;
	logic                     el_sat;
	logic [ELAPSED_W-1:0]     elapsed;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = !seq_active;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// range selection of the requested wait
	assign in_short = (s_tdata <= RANGE_SHORT_MS);
	assign in_long  = (s_tdata > RANGE_MID_MS);
	assign psc_sel  = in_short ? '0 : (in_long ? PRESCALE_LONG : PRESCALE_MID);

	// a tick advances the counter when the prescaler wraps; once it has reached reload it expires
	assign tick_wrap   = enabled_q && (psc_cnt_q >= psc_val_q);
	assign tick_expire = (s_tuser == REQ_TICK) && tick_wrap && (up_cnt_q >= reload_q);

	assign seq_cond.is_start  = start_q;
	assign seq_cond.short_rng = short_q;
	assign seq_cond.div_busy  = div_busy;
	assign seq_cond.out_full  = m_tvalid_q && !m_tready;

	mots_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.launch (accept),
		.cond   (seq_cond),
		.cw     (seq_cw),
		.active (seq_active),
		.go     (seq_go)
	);

	// shared multiplier operands; the product is registered in mul_q
	always_comb begin
		case (seq_cw.mul_a)
			MA_Q1: begin
				mul_a_op = q1_q;
				mul_b_op = tpm_q;
			end
			MA_R1: begin
				mul_a_op = MUL_A_W'(r1_q);
				mul_b_op = tpm_q;
			end
			MA_MS: begin
				mul_a_op = ms_q;
				mul_b_op = tpm_q;
			end
			MA_CNT: begin
				mul_a_op = MUL_A_W'(up_cnt_q);
				mul_b_op = MUL_B_W'(psc_val_q) + MUL_B_W'(1);
			end
			default: begin
				mul_a_op = '0;
				mul_b_op = '0;
			end
		endcase
	end

	assign mul_res = MUL_W'(mul_a_op) * MUL_W'(mul_b_op);

	// division by 1000 or 30000: register the reciprocal product, take the quotient from
	// its upper bits a step later and the remainder by multiplying back
	assign kdiv_start = seq_go && ((seq_cw.div_op == DV_MS_K) || (seq_cw.div_op == DV_MUL_K));
	assign kdiv_x     = (seq_cw.div_op == DV_MS_K) ? ms_q : mul_q[MS_W-1:0];
	assign kdiv_m     = long_q ? RECIP_LONG : RECIP_MS_PER_S;
	assign kdiv_d     = MS_W'(long_q ? DIV_LONG : MS_PER_S);
	assign kquo       = long_q ? MS_W'(kprod_q >> SHIFT_LONG) : MS_W'(kprod_q >> SHIFT_MS_PER_S);
	assign krem       = ms_q - kquo * kdiv_d;

	// serial divider: counter*(prescale+1) by ticks_per_ms for the elapsed time
	assign div_start    = seq_go && (seq_cw.div_op == DV_MUL_TPM);
	assign div_dividend = DIV_W'(mul_q);
	assign div_divisor  = tpm_q;

	mots_div #(
		.DW (DIV_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.busy      (div_busy),
		.quotient  (div_quo)
	);

	// reload plus calibration offset, saturated to the counter range
	assign rel_sum = acc_q + ACC_W'(ofs_q);
	assign rel_sat = (rel_sum > ACC_W'(CNT_MAX));

	// elapsed time saturates at 32 bits; a zero divisor reads all ones
	assign el_sat  = (64'(div_quo) > 64'h0000_0000_FFFF_FFFF);
	assign elapsed = ((tpm_q == '0) || el_sat) ? '1 : div_quo[ELAPSED_W-1:0];

	// configuration registers and timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpm_q     <= TPM_RESET;
			ofs_q     <= '0;
			enabled_q <= 1'b0;
			psc_val_q <= '0;
			psc_cnt_q <= '0;
			up_cnt_q  <= '0;
			reload_q  <= CNT_MAX;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TICKS_PER_MS: tpm_q <= cfg_data;
					REG_CAL_OFFSET:   ofs_q <= cfg_data[OFS_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				case (s_tuser)
					REQ_TICK: begin
						if (enabled_q) begin
							if (tick_wrap) begin
								psc_cnt_q <= '0;
								if (tick_expire) begin
									// one-shot: clear the counter and stop
									up_cnt_q  <= '0;
									enabled_q <= 1'b0;
								end else begin
									up_cnt_q <= up_cnt_q + COUNTER_WIDTH'(1);
								end
							end else begin
								psc_cnt_q <= psc_cnt_q + PSC_W'(1);
							end
						end
					end
					REQ_START: begin
						// reload follows from the microprogram before the result leaves
						psc_val_q <= psc_sel;
						psc_cnt_q <= '0;
						up_cnt_q  <= '0;
						enabled_q <= 1'b1;
					end
					REQ_STOP: enabled_q <= 1'b0;
					default: ;
				endcase
			end
			if (seq_go && seq_cw.wr_reload) begin
				reload_q <= rel_sat ? CNT_MAX : rel_sum[COUNTER_WIDTH-1:0];
			end
		end
	end

	// item capture and datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			ms_q    <= s_tdata;
			start_q <= (s_tuser == REQ_START);
			short_q <= in_short;
			long_q  <= in_long;
			exp_q   <= tick_expire;
		end
		if (seq_go && (seq_cw.mul_a != MA_NONE)) begin
			mul_q <= mul_res;
		end
		if (kdiv_start) begin
			kprod_q <= KPROD_W'(kdiv_x) * KPROD_W'(kdiv_m);
		end
		if (seq_go && seq_cw.latch_q1) begin
			q1_q <= kquo;
			r1_q <= krem[PSC_W-1:0];
		end
		if (seq_go) begin
			case (seq_cw.acc_op)
				ACC_LOAD:  acc_q <= ACC_W'(mul_q);
				ACC_ADD_Q: acc_q <= acc_q + ACC_W'(kquo);
				default: ;
			endcase
		end
		if (seq_go && seq_cw.emit) begin
			m_tdata_q <= OUT_DATA_W'({elapsed, enabled_q, exp_q});
		end
	end

	// output register: hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (seq_go && seq_cw.emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	`MOTS_ASSERT_NEXT(a_launch_runs, s_tvalid && s_tready, seq_active, "program not started after input transfer")
	`MOTS_ASSERT_NOW(a_div_idle, div_start, !div_busy, "divider restarted while busy")
	`MOTS_ASSERT_NEXT(a_emit_lands, seq_go && seq_cw.emit, m_tvalid && !seq_active, "result not placed in output register")
	`MOTS_ASSERT_NOW(a_expiry_stops, m_tvalid && m_tdata[0], !m_tdata[1], "expiry reported while timer still running")

endmodule

>>> tb/mots_result_checker.sv
// Result checker for the one-shot millisecond timer: watches all channels, predicts, compares
`timescale 1ns / 1ps
module mots_result_checker import mots_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [IN_USER_W-1:0]  s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [TPM_W-1:0]      cfg_data,
	output int                    errors,
	output int                    pending,
	output int                    n_results,
	output int                    n_expiries
);

	localparam int PRINT_CAP = 100;

	// lowest bit first on the bus: expired, running, elapsed_ms
	typedef struct packed {
		logic [ELAPSED_W-1:0] elapsed_ms;
		logic                 running;
		logic                 expired;
	} timer_status_t;

	// own copy of the configuration and timer state
	logic [TPM_W-1:0]     tpm;
	logic [OFS_W-1:0]     ofs;
	logic                 tmr_on;
	logic [PSC_W-1:0]     psc_val;
	logic [PSC_W-1:0]     psc_cnt;
	logic [31:0]          count;
	logic [31:0]          reload;

	timer_status_t awaited_status[$];
	timer_status_t want;
	timer_status_t got;

	function automatic logic [31:0] reload_for(input logic [MS_W-1:0] ms,
		output logic [PSC_W-1:0] psc);
		longint unsigned m;
		longint unsigned t;
		longint unsigned r;
		m = 64'(ms);
		t = 64'(tpm);
		if (ms <= RANGE_SHORT_MS) begin
			psc = '0;
			r = t * m;
		end else if (ms <= RANGE_MID_MS) begin
			psc = PRESCALE_MID;
			r = t * (m / 64'(MS_PER_S)) + (t * (m % 64'(MS_PER_S))) / 64'(MS_PER_S);
		end else begin
			psc = PRESCALE_LONG;
			r = t * (m / 64'(DIV_LONG)) + (t * (m % 64'(DIV_LONG))) / 64'(DIV_LONG);
		end
		r = r + 64'(ofs);
		if (r > 64'hFFFF_FFFF)
			r = 64'hFFFF_FFFF;
		return r[31:0];
	endfunction

	function automatic logic [ELAPSED_W-1:0] elapsed_now();
		longint unsigned p;
		if (tpm == '0)
			return '1;
		p = (64'(count) * (64'(psc_val) + 64'd1)) / 64'(tpm);
		if (p > 64'hFFFF_FFFF)
			p = 64'hFFFF_FFFF;
		return p[31:0];
	endfunction

	// advance the timer by one request and give the status it reports
	task automatic predict_status(input logic [1:0] req, input logic [MS_W-1:0] ms,
		output timer_status_t res);
		logic [PSC_W-1:0] psc;
		logic             fired;
		fired = 1'b0;
		case (req)
			REQ_TICK: begin
				if (tmr_on) begin
					if (psc_cnt >= psc_val) begin
						psc_cnt = '0;
						if (count >= reload) begin
							count  = '0;
							tmr_on = 1'b0;
							fired  = 1'b1;
						end else begin
							count = count + 32'd1;
						end
					end else begin
						psc_cnt = psc_cnt + PSC_W'(1);
					end
				end
			end
			REQ_START: begin
				reload  = reload_for(ms, psc);
				psc_val = psc;
				psc_cnt = '0;
				count   = '0;
				tmr_on  = 1'b1;
			end
			REQ_STOP: tmr_on = 1'b0;
			default: ;
		endcase
		res.expired    = fired;
		res.running    = tmr_on;
		res.elapsed_ms = elapsed_now();
	endtask

	task automatic report_mismatch(input string what, input longint unsigned g,
		input longint unsigned w);
		if (errors < PRINT_CAP)
			$display("%0t: mismatch on result %0d, %s: got %0h, expected %0h",
				$realtime, n_results, what, g, w);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpm        = TPM_RESET;
			ofs        = '0;
			tmr_on     = 1'b0;
			psc_val    = '0;
			psc_cnt    = '0;
			count      = '0;
			reload     = '1;
			awaited_status.delete();
			errors     = 0;
			pending    = 0;
			n_results  = 0;
			n_expiries = 0;
		end else begin
			// compare before predicting: a result never belongs to an item taken this edge
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(timer_status_t)-1:0];
				if (awaited_status.size() == 0) begin
					report_mismatch("result with nothing outstanding", m_tdata, 0);
				end else begin
					want = awaited_status.pop_front();
					if (got.expired !== want.expired)
						report_mismatch("expired", got.expired, want.expired);
					if (got.running !== want.running)
						report_mismatch("running", got.running, want.running);
					if (got.elapsed_ms !== want.elapsed_ms)
						report_mismatch("elapsed_ms", got.elapsed_ms, want.elapsed_ms);
					if (want.expired)
						n_expiries++;
				end
				n_results++;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_TICKS_PER_MS)
					tpm = cfg_data;
				else
					ofs = cfg_data[OFS_W-1:0];
			end
			if (s_tvalid && s_tready) begin
				predict_status(s_tuser, s_tdata, want);
				awaited_status.push_back(want);
			end
			pending = awaited_status.size();
		end
	end

endmodule

>>> tb/tb_top.sv
// Testbench top of the one-shot millisecond timer: stimulus, idling, watchdog and verdict
`timescale 1ns / 1ps
module tb_top;
	import mots_pkg::*;

	// selector three carries no request; the block must report status only
	localparam logic [IN_USER_W-1:0] REQ_IGNORED = 2'd3;

	localparam int RESET_CYCLES     = 8;
	localparam int WATCHDOG_LIMIT   = 4000;  // well above the longest start plus stalls
	localparam int TAIL_CYCLES      = 200;   // covers the longest start
	localparam int ITEMS_PER_PHASE  = 56;
	localparam int MID_RANGE_TICKS  = 20;    // partway through a prescale of 999
	localparam int N_PHASES         = 8;
	localparam int RANDOM_SETTING   = -1;

	// per phase: ticks per ms, offset, sender idle and receiver stall percentages
	int ph_tpm   [N_PHASES] = '{1, 3, 2, 1, 131071, 0, RANDOM_SETTING, RANDOM_SETTING};
	int ph_ofs   [N_PHASES] = '{0, 1, 5, 1023, 0, 3, RANDOM_SETTING, RANDOM_SETTING};
	int ph_send  [N_PHASES] = '{0, 50, 0, 31, 0, 50, 0, 31};
	int ph_stall [N_PHASES] = '{0, 0, 50, 31, 0, 0, 50, 31};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;   // [31:0] duration_ms
	logic [IN_USER_W-1:0]  s_tuser;   // [1:0] req_type
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;   // [0] expired, [1] running, [33:2] elapsed_ms
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic                  cfg_index;
	logic [TPM_W-1:0]      cfg_data;

	int errors;
	int pending;
	int n_results;
	int n_expiries;
	int n_items;
	int send_pct;
	int stall_pct;
	int cur_tpm;
	int cur_ofs;
	int idle_cycles;

	millisecond_one_shot_timer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	mots_result_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.errors     (errors),
		.pending    (pending),
		.n_results  (n_results),
		.n_expiries (n_expiries)
	);

	always #5 clk = ~clk;

	// receiver side: stall at random with the phase's percentage
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// watchdog: any cycle without a transfer on any channel counts towards the limit
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
				idle_cycles, pending);
			$display("FAILURE");
			$finish;
		end
	end

	// Offer one item. Idle gaps come first so that they fall before every kind of
	// request. Readiness is sampled at the falling edge, where it is stable; the
	// transfer then takes place at the next rising edge. tvalid stays high on exit
	// so that back-to-back items need no second assignment in the same step.
	task automatic send_item(input logic [IN_USER_W-1:0] req, input logic [MS_W-1:0] ms);
		while ($urandom_range(0, 99) < send_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= ms;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		if (req != REQ_IGNORED)
			n_items++;
	endtask

	// write one register; the block is idle whenever this is called
	task automatic write_reg(input reg_idx_t idx, input logic [TPM_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// drop tvalid and hold until every awaited result has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// One random sequence. Most are a start sized so that the reload stays small,
	// then enough ticks to run it out, with the odd stop, restart or ignored
	// selector mixed in; some are cut short. The rest is pure noise.
	task automatic run_sequence();
		logic [MS_W-1:0] ms;
		int              r_est;
		int              n;
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 6))
				send_item(IN_USER_W'($urandom_range(0, 3)), $urandom);
		end else begin
			if (cur_tpm == 0)
				ms = $urandom_range(0, RANGE_SHORT_MS);
			else if (cur_tpm <= 40)
				ms = $urandom_range(0, 40 / cur_tpm);
			else
				ms = ($urandom_range(0, 3) == 0) ? 1 : 0;
			r_est = (cur_tpm == 0) ? cur_ofs : cur_tpm * int'(ms) + cur_ofs;
			n = (r_est <= 48) ? r_est + 1 + $urandom_range(0, 2) : $urandom_range(4, 24);
			if ($urandom_range(0, 3) == 0)
				n = $urandom_range(0, n);
			send_item(REQ_START, ms);
			repeat (n) begin
				case ($urandom_range(0, 15))
					0:       send_item(REQ_STOP, $urandom);
					1:       send_item(REQ_IGNORED, $urandom);
					2:       send_item(REQ_START, ms);
					default: send_item(REQ_TICK, $urandom);
				endcase
			end
		end
	endtask

	initial begin
		int target;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = REQ_TICK;
		cfg_valid = 1'b0;
		cfg_index = REG_TICKS_PER_MS;
		cfg_data  = '0;
		send_pct  = 0;
		stall_pct = 0;
		n_items   = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset configuration: stopped timer, zero wait, range edges
		send_item(REQ_TICK, '0);              // tick while stopped
		send_item(REQ_IGNORED, '1);           // selector three with all-ones data
		send_item(REQ_STOP, '0);
		send_item(REQ_START, '0);             // zero wait: reload is just the offset
		send_item(REQ_TICK, '0);              // expires at once
		send_item(REQ_TICK, '0);              // after expiry the counter reads zero
		send_item(REQ_START, 32'd1);
		repeat (3) send_item(REQ_TICK, '1);
		send_item(REQ_STOP, '0);              // stop keeps the counter
		send_item(REQ_TICK, '0);
		send_item(REQ_START, RANGE_SHORT_MS);
		send_item(REQ_START, RANGE_SHORT_MS + 1);   // restart while running, mid range
		send_item(REQ_TICK, '0);
		send_item(REQ_START, RANGE_MID_MS);
		send_item(REQ_START, RANGE_MID_MS + 1);     // long range
		send_item(REQ_START, '1);             // reload saturates
		send_item(REQ_TICK, '0);
		send_item(REQ_IGNORED, '0);
		send_item(REQ_STOP, '1);
		drain();

		// zero ticks per ms: a mid-range start counts through its prescaler
		cur_tpm = 0;
		cur_ofs = 0;
		write_reg(REG_TICKS_PER_MS, TPM_W'(cur_tpm));
		write_reg(REG_CAL_OFFSET, TPM_W'(cur_ofs));
		send_item(REQ_START, RANGE_SHORT_MS + 1);
		repeat (MID_RANGE_TICKS) send_item(REQ_TICK, $urandom);
		drain();

		// random phases, each with its own configuration and idling pattern
		for (int p = 0; p < N_PHASES; p++) begin
			cur_tpm = (ph_tpm[p] == RANDOM_SETTING) ? $urandom_range(1, 7) : ph_tpm[p];
			cur_ofs = (ph_ofs[p] == RANDOM_SETTING) ? $urandom_range(0, 7) : ph_ofs[p];
			write_reg(REG_TICKS_PER_MS, TPM_W'(cur_tpm));
			write_reg(REG_CAL_OFFSET, TPM_W'(cur_ofs));
			send_pct  = ph_send[p];
			stall_pct = ph_stall[p];
			target    = n_items + ITEMS_PER_PHASE;
			while (n_items < target)
				run_sequence();
			drain();
		end

		// let any stray result surface before the verdict
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Run covered %0d requests and %0d checked results, %0d of them expiries,",
			n_items, n_results, n_expiries);
		$display("over ticks_per_ms 0 to 131071, offsets 0 to 1023 and four idling patterns.");
		if (errors == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches, %0d results still awaited", errors, pending);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
